// ----- hw/rtl/mmq_pkg.sv -----
`timescale 1ns / 1ps
package mmq_pkg;

	localparam int DATA_W    = 32;
	localparam int CODE_W    = 16;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;

	// Offset that moves an unsigned quotient onto the signed code range
	localparam logic [CODE_W-1:0] CODE_BIAS = 16'h8000;

	localparam logic signed [DATA_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] MAX_RESET = 32'sh8000_0000;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic store;     // take the incoming sample
		logic clear;     // return the vector state to reset
		logic range_ld;  // latch the scaling bounds
		logic rd;        // read the store at the current index
		logic diff_ld;   // latch sample minus low bound
		logic num_ld;    // latch the scaled numerator into the divider
		logic div_step;  // one restoring division step
		logic out_ld;    // load the output register
		logic k_inc;     // advance the read index
	} dp_cmd_t;

endpackage

// ----- hw/rtl/mmq_in_if.sv -----
`timescale 1ns / 1ps
interface mmq_in_if;
	logic                valid;
	logic                ready;
	logic signed [31:0]  sample;
	logic                final_sample;

	modport source (output valid, output sample, output final_sample, input ready);
	modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

// ----- hw/rtl/mmq_out_if.sv -----
`timescale 1ns / 1ps
interface mmq_out_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  code;
	logic signed [31:0]  range_low;
	logic signed [31:0]  range_high;
	logic                last_code;
	logic                overflowed;

	modport source (output valid, output code, output range_low, output range_high,
		output last_code, output overflowed, input ready);
	modport sink   (input valid, input code, input range_low, input range_high,
		input last_code, input overflowed, output ready);
endinterface

// ----- hw/rtl/mmq_ram.sv -----
`timescale 1ns / 1ps
module mmq_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/mmq_ctrl.sv -----
`timescale 1ns / 1ps
module mmq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_final,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	input  logic             last,
	output mmq_pkg::dp_cmd_t cmd
);
	import mmq_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RANGE,
		ST_READ,
		ST_DIFF,
		ST_NUM,
		ST_DIV,
		ST_PUT
	} state_t;

	state_t                 state_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   out_valid_q;
	logic                   put_ok;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;
	assign put_ok    = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD:  cmd.store    = in_valid;
			ST_RANGE: cmd.range_ld = 1'b1;
			ST_READ:  cmd.rd       = 1'b1;
			ST_DIFF:  cmd.diff_ld  = 1'b1;
			ST_NUM:   cmd.num_ld   = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_PUT: begin
				cmd.out_ld = put_ok;
				cmd.clear  = put_ok && last;
				cmd.k_inc  = put_ok && !last;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_valid && in_final) begin
						state_q <= ST_RANGE;
					end
				end
				ST_RANGE: state_q <= ST_READ;
				ST_READ:  state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_NUM;
				ST_NUM: begin
					cnt_q   <= DIV_CNT_W'(DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_PUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_PUT: begin
					if (put_ok) begin
						state_q <= last ? ST_LOAD : ST_READ;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

// ----- hw/rtl/mmq_dp.sv -----
`timescale 1ns / 1ps
module mmq_dp #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mmq_pkg::dp_cmd_t                 cmd,
	output logic                             last,
	input  logic signed [mmq_pkg::DATA_W-1:0] sample,
	output logic signed [mmq_pkg::CODE_W-1:0] code,
	output logic signed [mmq_pkg::DATA_W-1:0] range_low,
	output logic signed [mmq_pkg::DATA_W-1:0] range_high,
	output logic                             last_code,
	output logic                             overflowed
);
	import mmq_pkg::*;

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);

	logic [CW-1:0]              count_q;
	logic [AW-1:0]              k_q;
	logic signed [DATA_W-1:0]   min_q;
	logic signed [DATA_W-1:0]   max_q;
	logic                       dropped_q;

	logic signed [DATA_W:0]     low_q;
	logic [DATA_W-1:0]          span_q;
	logic [DATA_W-1:0]          d_q;
	logic [DATA_W-1:0]          rem_q;
	logic [CODE_W-1:0]          quo_q;

	logic signed [CODE_W-1:0]   code_q;
	logic signed [DATA_W-1:0]   range_low_q;
	logic signed [DATA_W-1:0]   range_high_q;
	logic                       last_q;
	logic                       ovf_q;

	logic                       full;
	logic                       wr_en;
	logic [DATA_W-1:0]          rd_data;
	logic signed [DATA_W:0]     diff;
	logic [DATA_W+CODE_W-1:0]   num;
	logic [DATA_W:0]            trial;
	logic                       fits;
	logic                       round_up;

	assign full  = (count_q == CW'(STORE_DEPTH));
	assign wr_en = cmd.store && !full;
	assign last  = ((CW'(k_q) + CW'(1)) == count_q);

	mmq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH),
		.ADDR_W(AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(sample),
		.rd_en  (cmd.rd),
		.rd_addr(k_q),
		.rd_data(rd_data)
	);

	// x - low is never negative and fits 32 bits unsigned
	assign diff = {rd_data[DATA_W-1], rd_data} - low_q;
	// d * 65535 as (d << 16) - d
	assign num  = {d_q, {CODE_W{1'b0}}} - {{CODE_W{1'b0}}, d_q};
	assign trial = {rem_q, quo_q[CODE_W-1]};
	assign fits  = (trial >= {1'b0, span_q});
	// below the midpoint the code truncates toward zero, so round the quotient up
	assign round_up = !quo_q[CODE_W-1] && (rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			k_q       <= '0;
			min_q     <= MIN_RESET;
			max_q     <= MAX_RESET;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q   <= '0;
				k_q       <= '0;
				min_q     <= MIN_RESET;
				max_q     <= MAX_RESET;
				dropped_q <= 1'b0;
			end else begin
				if (cmd.store) begin
					if (full) begin
						dropped_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						if (sample < min_q) begin
							min_q <= sample;
						end
						if (sample > max_q) begin
							max_q <= sample;
						end
					end
				end
				if (cmd.k_inc) begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.range_ld) begin
			if (min_q == max_q) begin
				low_q  <= {max_q[DATA_W-1], max_q} - 1'sb1;
				span_q <= DATA_W'(1);
			end else begin
				low_q  <= {min_q[DATA_W-1], min_q};
				span_q <= DATA_W'(max_q - min_q);
			end
		end
		if (cmd.diff_ld) begin
			d_q <= diff[DATA_W-1:0];
		end
		if (cmd.num_ld) begin
			rem_q <= num[DATA_W+CODE_W-1:CODE_W];
			quo_q <= num[CODE_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= fits ? DATA_W'(trial - {1'b0, span_q}) : trial[DATA_W-1:0];
			quo_q <= {quo_q[CODE_W-2:0], fits};
		end
		if (cmd.out_ld) begin
			code_q       <= (quo_q + CODE_W'(round_up)) ^ CODE_BIAS;
			range_low_q  <= low_q[DATA_W-1:0];
			range_high_q <= max_q;
			last_q       <= last;
			ovf_q        <= dropped_q;
		end
	end

	assign code       = code_q;
	assign range_low  = range_low_q;
	assign range_high = range_high_q;
	assign last_code  = last_q;
	assign overflowed = ovf_q;

endmodule

// ----- hw/rtl/min_max_quantizer_16bit_top.sv -----
`timescale 1ns / 1ps
// Min/max linear quantizer: 32-bit signed samples in, 16-bit signed codes out.
// samples channel: one sample per transaction; final_sample closes the vector.
//   Samples load at one per cycle into a STORE_DEPTH-entry store while the
//   running minimum and maximum are tracked. Samples past the store depth are
//   dropped and flag the vector as overflowed.
// codes channel: after the closing sample, one transaction per stored sample,
//   in load order, each with the scaling bounds, overflow flag and last_code
//   on the final one.
// Sequencing: after the closing transaction the scaling bounds are latched;
//   each code then takes a store read, difference, scaling, the shared
//   restoring divider (16 steps) and the output load, one code at a time.
//   Samples are not taken while codes are being produced; the
//   next vector may start loading while the last code still waits.
// Reset clears the vector state (count, bounds, overflow) and the output
//   register's valid; store contents are not cleared.
// A stalled receiver holds the current code; the next one waits in the
//   divider until the output register frees up.
module min_max_quantizer_16bit_top #(
	parameter int STORE_DEPTH = 64
) (
	input logic     clk,
	input logic     arst_n,
	mmq_in_if.sink  samples,
	mmq_out_if.source codes
);
	import mmq_pkg::*;

	dp_cmd_t cmd;
	logic    last;

	// Sequence one vector: load, then per code read / scale / divide / put
	mmq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_final (samples.final_sample),
		.in_ready (samples.ready),
		.out_ready(codes.ready),
		.out_valid(codes.valid),
		.last     (last),
		.cmd      (cmd)
	);

	// Store, bound tracking, divider and output register
	mmq_dp #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.last      (last),
		.sample    (samples.sample),
		.code      (codes.code),
		.range_low (codes.range_low),
		.range_high(codes.range_high),
		.last_code (codes.last_code),
		.overflowed(codes.overflowed)
	);

	// Closing a vector stops the input until its codes are produced
	a_close_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready && samples.final_sample |=> !samples.ready)
		else $error("input taken right after closing sample");

	// No input while a non-final code of the vector is pending
	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && !codes.last_code |-> !samples.ready)
		else $error("input ready during code emission");

	// Hold the offered code while the receiver stalls
	a_stall_holds_code: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && !codes.ready |=> codes.valid && $stable(codes.code)
			&& $stable(codes.range_low) && $stable(codes.last_code))
		else $error("code changed while stalled");

endmodule
